// ===== rtl/core/gbs_pkg.sv =====
package gbs_pkg;

    // Kept-list depth and coordinate width
    localparam int MAX_KEPT   = 512;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_KEPT);
    localparam int CNT_W      = $clog2(MAX_KEPT + 1);

    // IoU threshold, unsigned Q0.16
    localparam int          THR_W     = 16;
    localparam logic [15:0] THR_RESET = 16'd19661;
    localparam int          ONE_SHIFT = 16;

    // Arithmetic widths (all signed)
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int AREA_W = 2 * DIFF_W;
    localparam int UN_W   = AREA_W + 1;
    localparam int MB_W   = (DIFF_W > THR_W + 1) ? DIFF_W : THR_W + 1;
    localparam int PROD_W = UN_W + MB_W;

    typedef struct packed {
        logic        first_of_set;
        logic [8:0]  cand_index;
        logic [1:0]  class_id;
        logic [15:0] box_x1;
        logic [15:0] box_y1;
        logic [15:0] box_x2;
        logic [15:0] box_y2;
    } in_beat_t;

    typedef struct packed {
        logic [8:0] out_index;
        logic [1:0] out_class;
        logic       kept;
        logic [9:0] kept_count;
        logic       overflow;
    } out_beat_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic [COORD_BITS-1:0] x2;
        logic [COORD_BITS-1:0] y2;
    } box_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AREA,
        ST_FETCH,
        ST_DIFF,
        ST_MUL_AREA,
        ST_MUL_OV,
        ST_UNION,
        ST_MUL_THR,
        ST_CMP,
        ST_DECIDE
    } state_t;

endpackage

// ===== rtl/core/greedy_box_suppression_unit.sv =====
// Greedy IoU suppression, one candidate at a time.
// Each candidate is compared against the kept boxes in order; the scan stops at the first
// suppressing box, and at most 512 kept boxes are compared.
// No new candidate until the last result is loaded; pace set by the shared multiplier,
// which is used three times per kept box, and the single read port of the kept-box RAM.
// Reset: kept count 0, threshold 19661 (~0.3), no result pending; RAM contents undefined.
module greedy_box_suppression_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  gbs_pkg::in_beat_t   in_beat,
    output logic                out_valid,
    input  logic                out_stall,
    output gbs_pkg::out_beat_t  out_beat
);

    // 1-D overlap: the interval with the smaller min goes first; on equal mins the
    // candidate interval stays first.
    function automatic logic signed [gbs_pkg::DIFF_W-1:0] ovl_1d
    (
        input logic [gbs_pkg::COORD_BITS-1:0] amin,
        input logic [gbs_pkg::COORD_BITS-1:0] amax,
        input logic [gbs_pkg::COORD_BITS-1:0] bmin,
        input logic [gbs_pkg::COORD_BITS-1:0] bmax
    );
        logic [gbs_pkg::COORD_BITS-1:0] pmax;
        logic [gbs_pkg::COORD_BITS-1:0] qmin;
        logic [gbs_pkg::COORD_BITS-1:0] qmax;
        logic [gbs_pkg::COORD_BITS-1:0] mn;
        logic signed [gbs_pkg::DIFF_W-1:0] res;
        if (amin > bmin)
        begin
            pmax = bmax;
            qmin = amin;
            qmax = amax;
        end
        else
        begin
            pmax = amax;
            qmin = bmin;
            qmax = bmax;
        end
        mn = (pmax < qmax) ? pmax : qmax;
        if (pmax < qmin)
            res = '0;
        else
            res = $signed({1'b0, mn}) - $signed({1'b0, qmin});
        return res;
    endfunction

    // ---------------- control state ----------------
    gbs_pkg::state_t           state_reg, state_next;
    logic [gbs_pkg::CNT_W-1:0] kept_total_reg, kept_total_next;
    logic [gbs_pkg::CNT_W-1:0] idx_reg, idx_next;   // scan position in kept list
    logic                      pass_reg, pass_next; // no suppressing box found so far
    logic                      out_valid_reg, out_valid_next;
    logic [gbs_pkg::THR_W-1:0] thr_reg;

    // ---------------- datapath registers ----------------
    gbs_pkg::in_beat_t              cand_reg;
    gbs_pkg::box_t                  cand_box;
    gbs_pkg::out_beat_t             out_beat_reg;
    logic signed [gbs_pkg::DIFF_W-1:0] cw_reg, ch_reg;   // candidate width/height
    logic signed [gbs_pkg::DIFF_W-1:0] bw_reg, bh_reg;   // kept box width/height
    logic signed [gbs_pkg::DIFF_W-1:0] ox_reg, oy_reg;   // overlaps
    logic signed [gbs_pkg::AREA_W-1:0] area_a_reg, area_b_reg, ov_reg;
    logic signed [gbs_pkg::UN_W-1:0]   un_reg;
    logic signed [gbs_pkg::PROD_W-1:0] rhs_reg;

    // kept-box RAM, one read and one write port, registered read
    gbs_pkg::box_t             kept_mem [gbs_pkg::MAX_KEPT];
    gbs_pkg::box_t             rd_box_reg;
    logic                      mem_rd_en;
    logic                      mem_wr_en;

    // shared multiplier
    logic signed [gbs_pkg::UN_W-1:0]   mul_a;
    logic signed [gbs_pkg::MB_W-1:0]   mul_b;
    logic signed [gbs_pkg::PROD_W-1:0] mul_p;

    logic signed [gbs_pkg::PROD_W-1:0] lhs;
    logic                              iou_ok;
    logic                              list_full;
    logic                              do_keep;
    logic                              out_free;
    logic                              load_out;
    logic                              in_take;

    assign cand_box.x1 = cand_reg.box_x1[gbs_pkg::COORD_BITS-1:0];
    assign cand_box.y1 = cand_reg.box_y1[gbs_pkg::COORD_BITS-1:0];
    assign cand_box.x2 = cand_reg.box_x2[gbs_pkg::COORD_BITS-1:0];
    assign cand_box.y2 = cand_reg.box_y2[gbs_pkg::COORD_BITS-1:0];

    assign in_stall  = (state_reg != gbs_pkg::ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    // Output register frees when empty or being drained this cycle.
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = (state_reg == gbs_pkg::ST_DECIDE) && out_free;

    assign list_full = (kept_total_reg == gbs_pkg::CNT_W'(gbs_pkg::MAX_KEPT));
    assign do_keep   = pass_reg && !list_full;
    assign mem_wr_en = load_out && do_keep;
    assign mem_rd_en = (state_reg == gbs_pkg::ST_FETCH) && (idx_reg != kept_total_reg);

    // overlap*65536 <= thr*union, zero union always passes
    assign lhs    = gbs_pkg::PROD_W'(ov_reg) <<< gbs_pkg::ONE_SHIFT;
    assign iou_ok = (un_reg == '0) || (lhs <= rhs_reg);

    // Operand select for the shared multiplier; each product lands in a register.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            gbs_pkg::ST_AREA:
            begin
                mul_a = gbs_pkg::UN_W'(cw_reg);
                mul_b = gbs_pkg::MB_W'(ch_reg);
            end
            gbs_pkg::ST_MUL_AREA:
            begin
                mul_a = gbs_pkg::UN_W'(bw_reg);
                mul_b = gbs_pkg::MB_W'(bh_reg);
            end
            gbs_pkg::ST_MUL_OV:
            begin
                mul_a = gbs_pkg::UN_W'(ox_reg);
                mul_b = gbs_pkg::MB_W'(oy_reg);
            end
            gbs_pkg::ST_MUL_THR:
            begin
                mul_a = un_reg;
                mul_b = $signed(gbs_pkg::MB_W'({1'b0, thr_reg}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gbs_pkg::ST_IDLE;
            kept_total_reg <= '0;
            idx_reg        <= '0;
            pass_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            thr_reg        <= gbs_pkg::THR_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            kept_total_reg <= kept_total_next;
            idx_reg        <= idx_next;
            pass_reg       <= pass_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
                thr_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        kept_total_next = kept_total_reg;
        idx_next        = idx_reg;
        pass_next       = pass_reg;
        out_valid_next  = out_valid_reg && out_stall;
        case (state_reg)
            gbs_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    if (in_beat.first_of_set)
                        kept_total_next = '0;
                    idx_next   = '0;
                    state_next = gbs_pkg::ST_AREA;
                end
            end
            gbs_pkg::ST_AREA:
            begin
                pass_next  = 1'b1;
                state_next = gbs_pkg::ST_FETCH;
            end
            gbs_pkg::ST_FETCH:
            begin
                // scan ends when every kept box has been compared
                if (idx_reg == kept_total_reg)
                    state_next = gbs_pkg::ST_DECIDE;
                else
                    state_next = gbs_pkg::ST_DIFF;
            end
            gbs_pkg::ST_DIFF:     state_next = gbs_pkg::ST_MUL_AREA;
            gbs_pkg::ST_MUL_AREA: state_next = gbs_pkg::ST_MUL_OV;
            gbs_pkg::ST_MUL_OV:   state_next = gbs_pkg::ST_UNION;
            gbs_pkg::ST_UNION:    state_next = gbs_pkg::ST_MUL_THR;
            gbs_pkg::ST_MUL_THR:  state_next = gbs_pkg::ST_CMP;
            gbs_pkg::ST_CMP:
            begin
                if (iou_ok)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = gbs_pkg::ST_FETCH;
                end
                else
                begin
                    // first suppressing box ends the scan
                    pass_next  = 1'b0;
                    state_next = gbs_pkg::ST_DECIDE;
                end
            end
            gbs_pkg::ST_DECIDE:
            begin
                // wait here only while the previous result is still held
                if (out_free)
                begin
                    if (do_keep)
                        kept_total_next = kept_total_reg + 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = gbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gbs_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        if (in_take)
            cand_reg <= in_beat;
        case (state_reg)
            gbs_pkg::ST_IDLE:
            begin
                cw_reg <= $signed({1'b0, in_beat.box_x2[gbs_pkg::COORD_BITS-1:0]})
                        - $signed({1'b0, in_beat.box_x1[gbs_pkg::COORD_BITS-1:0]});
                ch_reg <= $signed({1'b0, in_beat.box_y2[gbs_pkg::COORD_BITS-1:0]})
                        - $signed({1'b0, in_beat.box_y1[gbs_pkg::COORD_BITS-1:0]});
            end
            gbs_pkg::ST_AREA:
                area_a_reg <= mul_p[gbs_pkg::AREA_W-1:0];
            gbs_pkg::ST_DIFF:
            begin
                ox_reg <= ovl_1d(cand_box.x1, cand_box.x2, rd_box_reg.x1, rd_box_reg.x2);
                oy_reg <= ovl_1d(cand_box.y1, cand_box.y2, rd_box_reg.y1, rd_box_reg.y2);
                bw_reg <= $signed({1'b0, rd_box_reg.x2}) - $signed({1'b0, rd_box_reg.x1});
                bh_reg <= $signed({1'b0, rd_box_reg.y2}) - $signed({1'b0, rd_box_reg.y1});
            end
            gbs_pkg::ST_MUL_AREA:
                area_b_reg <= mul_p[gbs_pkg::AREA_W-1:0];
            gbs_pkg::ST_MUL_OV:
                ov_reg <= mul_p[gbs_pkg::AREA_W-1:0];
            gbs_pkg::ST_UNION:
                un_reg <= gbs_pkg::UN_W'(area_a_reg) + gbs_pkg::UN_W'(area_b_reg)
                        - gbs_pkg::UN_W'(ov_reg);
            gbs_pkg::ST_MUL_THR:
                rhs_reg <= mul_p;
            default:
            begin
            end
        endcase

        if (load_out)
        begin
            out_beat_reg.out_index  <= cand_reg.cand_index;
            out_beat_reg.out_class  <= cand_reg.class_id;
            out_beat_reg.kept       <= do_keep;
            out_beat_reg.overflow   <= pass_reg && list_full;
            out_beat_reg.kept_count <= 10'(kept_total_reg + gbs_pkg::CNT_W'(do_keep));
        end
    end

    // kept-box RAM
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            kept_mem[kept_total_reg[gbs_pkg::IDX_W-1:0]] <= cand_box;
        if (mem_rd_en)
            rd_box_reg <= kept_mem[idx_reg[gbs_pkg::IDX_W-1:0]];
    end

endmodule

// ===== rtl/core/gbs_checker.sv =====
module gbs_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input gbs_pkg::out_beat_t out_beat
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_beat))
        else $error("result beat changed while stalled");

    // an accepted candidate occupies the block on the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a beat");

    a_kept_xor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_beat.kept && out_beat.overflow))
        else $error("kept and overflow both set");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_beat.kept_count <= 10'(gbs_pkg::MAX_KEPT))
        else $error("kept count beyond list depth");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.overflow |-> out_beat.kept_count == 10'(gbs_pkg::MAX_KEPT))
        else $error("overflow with list not full");

endmodule

bind greedy_box_suppression_unit gbs_checker u_gbs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
);
